// File: design/sssf_pkg.sv
// Shared types, codes and constants for the sensor sample scheduler and framer.
// Used by every module in this folder; no dependencies of its own.
`default_nettype none

package sssf_pkg;

    localparam int BASE_RATE        = 200000;
    localparam int DEFAULT_FREQ     = 600;
    localparam int FRAME_LENGTH_DEF = 21;
    localparam int HEADER_LEN       = 3;

    localparam logic [15:0] RELOAD_RESET   = 16'(BASE_RATE / (2 * DEFAULT_FREQ));
    localparam logic [7:0]  TEMP_RATE_RESET = 8'd25;
    localparam logic [7:0]  PRES_RATE_RESET = 8'd20;

    localparam logic [7:0] SYNC_BYTE0     = 8'h85;
    localparam logic [7:0] SYNC_BYTE1     = 8'h75;
    localparam logic [7:0] KIND_TEMP_CODE = 8'h10;
    localparam logic [7:0] KIND_PRES_CODE = 8'h20;
    localparam logic [7:0] TEMP_CHANNEL   = 8'd3;

    typedef enum logic {
        OP_TICK     = 1'b0,
        OP_PRESSURE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        REG_TICK_RELOAD = 2'd0,
        REG_TEMP_RATE   = 2'd1,
        REG_PRES_RATE   = 2'd2
    } reg_idx_t;

    typedef enum logic {
        KIND_TEMP = 1'b0,
        KIND_PRES = 1'b1
    } kind_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } q_stat_t;

    function automatic logic [7:0] kind_code(input logic kind);
        return (kind == KIND_PRES) ? KIND_PRES_CODE : KIND_TEMP_CODE;
    endfunction

endpackage

`default_nettype wire

// File: design/sssf_front.sv
// Front end: config registers, tick divider, rate counters and frame fill.
// Depends on sssf_pkg; pushes completed payloads into sssf_queue.
`default_nettype none

module sssf_front
    import sssf_pkg::*;
#(
    parameter int FRAME_LENGTH = FRAME_LENGTH_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [1:0]                             cfg_index,
    input  wire logic [15:0]                            cfg_data,
    input  wire logic                                   accept,
    input  wire logic                                   operation,
    input  wire logic [7:0]                             channel,
    input  wire logic [15:0]                            temperature_sample,
    input  wire logic [23:0]                            pressure_sample,
    output logic                                        push,
    output logic                                        push_kind,
    output logic [(FRAME_LENGTH-HEADER_LEN)*8-1:0]      push_payload
);

    localparam int PAY_W  = (FRAME_LENGTH - HEADER_LEN) * 8;
    localparam int FILL_W = $clog2(FRAME_LENGTH + 3);

    logic [15:0]       tick_reload_reg;
    logic [7:0]        temp_rate_reg;
    logic [7:0]        pres_rate_reg;
    logic [15:0]       divider_reg;
    logic [15:0]       divider_next;
    logic [7:0]        temp_tick_reg;
    logic [7:0]        temp_tick_next;
    logic [7:0]        pres_tick_reg;
    logic [7:0]        pres_tick_next;
    logic [FILL_W-1:0] temp_fill_reg;
    logic [FILL_W-1:0] temp_fill_next;
    logic [FILL_W-1:0] pres_fill_reg;
    logic [FILL_W-1:0] pres_fill_next;
    logic [PAY_W-1:0]  temp_pay_reg;
    logic [PAY_W-1:0]  temp_pay_next;
    logic [PAY_W-1:0]  pres_pay_reg;
    logic [PAY_W-1:0]  pres_pay_next;

    logic [15:0]       div_dec;
    logic              tick_fire;
    logic [7:0]        temp_inc;
    logic [7:0]        pres_inc;
    logic              temp_cap;
    logic              pres_cap;
    logic [FILL_W-1:0] sel_fill;
    logic [PAY_W-1:0]  sel_pay;
    logic [23:0]       sel_data;
    logic [1:0]        nbytes;
    logic [1:0]        nwrite;
    logic [FILL_W-1:0] room;
    logic [FILL_W-1:0] fill_sum;
    logic              frame_full;
    logic [FILL_W-1:0] fill_after;
    logic [PAY_W-1:0]  pay_after;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reload_reg <= RELOAD_RESET;
            temp_rate_reg   <= TEMP_RATE_RESET;
            pres_rate_reg   <= PRES_RATE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TICK_RELOAD: tick_reload_reg <= cfg_data;
                REG_TEMP_RATE:   temp_rate_reg   <= cfg_data[7:0];
                REG_PRES_RATE:   pres_rate_reg   <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    assign div_dec   = divider_reg - 16'd1;
    assign tick_fire = (operation == OP_TICK) && (div_dec == 16'd0);
    assign temp_inc  = temp_tick_reg + 8'd1;
    assign pres_inc  = pres_tick_reg + 8'd1;
    assign temp_cap  = tick_fire && (temp_inc > temp_rate_reg) && (channel == TEMP_CHANNEL);
    assign pres_cap  = (operation == OP_PRESSURE)
                    || (tick_fire && (pres_inc > pres_rate_reg) && (channel < TEMP_CHANNEL));

    assign sel_fill = temp_cap ? temp_fill_reg : pres_fill_reg;
    assign sel_pay  = temp_cap ? temp_pay_reg : pres_pay_reg;
    assign sel_data = temp_cap ? {temperature_sample, 8'h00} : pressure_sample;
    assign nbytes   = temp_cap ? 2'd2 : 2'd3;
    assign room     = FILL_W'(FRAME_LENGTH) - sel_fill;
    assign nwrite   = (room < FILL_W'(nbytes)) ? room[1:0] : nbytes;
    assign fill_sum = sel_fill + FILL_W'(nbytes);
    assign frame_full = fill_sum >= FILL_W'(FRAME_LENGTH);
    assign fill_after = frame_full ? FILL_W'(HEADER_LEN) : fill_sum;

    // bytes beyond the frame end are dropped
    always_comb
    begin
        logic [PAY_W-1:0] acc;
        acc = sel_pay;
        for (int i = 0; i < 3; i++)
        begin
            if (2'(i) < nwrite)
                acc = {acc[PAY_W-9:0], sel_data[23-8*i -: 8]};
        end
        pay_after = acc;
    end

    always_comb
    begin
        divider_next   = divider_reg;
        temp_tick_next = temp_tick_reg;
        pres_tick_next = pres_tick_reg;
        temp_fill_next = temp_fill_reg;
        pres_fill_next = pres_fill_reg;
        temp_pay_next  = temp_pay_reg;
        pres_pay_next  = pres_pay_reg;
        if (accept)
        begin
            if (operation == OP_TICK)
            begin
                divider_next = div_dec;
                if (tick_fire)
                begin
                    divider_next   = tick_reload_reg;
                    temp_tick_next = temp_cap ? 8'd0 : temp_inc;
                    pres_tick_next = pres_cap ? 8'd0 : pres_inc;
                end
            end
            if (temp_cap)
            begin
                temp_fill_next = fill_after;
                temp_pay_next  = pay_after;
            end
            else if (pres_cap)
            begin
                pres_fill_next = fill_after;
                pres_pay_next  = pay_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divider_reg   <= RELOAD_RESET;
            temp_tick_reg <= 8'd0;
            pres_tick_reg <= 8'd0;
            temp_fill_reg <= FILL_W'(HEADER_LEN);
            pres_fill_reg <= FILL_W'(HEADER_LEN);
        end
        else
        begin
            divider_reg   <= divider_next;
            temp_tick_reg <= temp_tick_next;
            pres_tick_reg <= pres_tick_next;
            temp_fill_reg <= temp_fill_next;
            pres_fill_reg <= pres_fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        temp_pay_reg <= temp_pay_next;
        pres_pay_reg <= pres_pay_next;
    end

    assign push         = accept && (temp_cap || pres_cap) && frame_full;
    assign push_kind    = temp_cap ? KIND_TEMP : KIND_PRES;
    assign push_payload = pay_after;

    a_temp_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (temp_fill_reg >= FILL_W'(HEADER_LEN)) && (temp_fill_reg < FILL_W'(FRAME_LENGTH)))
        else $error("temperature fill out of range");

    a_pres_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        (pres_fill_reg >= FILL_W'(HEADER_LEN)) && (pres_fill_reg < FILL_W'(FRAME_LENGTH)))
        else $error("pressure fill out of range");

endmodule

`default_nettype wire

// File: design/sssf_queue.sv
// Two-entry queue of completed frames between front end and serializer.
// Depends on sssf_pkg.
`default_nettype none

module sssf_queue
    import sssf_pkg::*;
#(
    parameter int FRAME_LENGTH = FRAME_LENGTH_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   push,
    input  wire logic                                   push_kind,
    input  wire logic [(FRAME_LENGTH-HEADER_LEN)*8-1:0] push_payload,
    input  wire logic                                   pop,
    output logic                                        head_kind,
    output logic [(FRAME_LENGTH-HEADER_LEN)*8-1:0]      head_payload,
    output q_stat_t                                     status
);

    localparam int PAY_W = (FRAME_LENGTH - HEADER_LEN) * 8;

    logic             kind_mem [2];
    logic [PAY_W-1:0] pay_mem  [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            kind_mem[wr_ptr_reg] <= push_kind;
            pay_mem[wr_ptr_reg]  <= push_payload;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    assign head_kind       = kind_mem[rd_ptr_reg];
    assign head_payload    = pay_mem[rd_ptr_reg];
    assign status.full     = count_reg == 2'd2;
    assign status.nonempty = count_reg != 2'd0;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != 2'd2))
        else $error("frame queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != 2'd0))
        else $error("frame queue underflow");

endmodule

`default_nettype wire

// File: design/sssf_back.sv
// Back end: takes frames from the queue and sends them byte by byte.
// Depends on sssf_pkg; output register decouples the receiver.
`default_nettype none

module sssf_back
    import sssf_pkg::*;
#(
    parameter int FRAME_LENGTH = FRAME_LENGTH_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire q_stat_t                                q_status,
    input  wire logic                                   head_kind,
    input  wire logic [(FRAME_LENGTH-HEADER_LEN)*8-1:0] head_payload,
    output logic                                        pop,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic [7:0]                                  frame_byte,
    output logic                                        frame_kind,
    output logic                                        frame_last
);

    localparam int PAY_W = (FRAME_LENGTH - HEADER_LEN) * 8;
    localparam int CNT_W = $clog2(FRAME_LENGTH);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_LENGTH - 1);

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_SEND = 2'b10
    } bk_state_t;

    bk_state_t        state_reg;
    bk_state_t        state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             kind_reg;
    logic             kind_next;
    logic [PAY_W-1:0] pay_reg;
    logic [PAY_W-1:0] pay_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_byte_reg;
    logic [7:0]       out_byte_next;
    logic             out_kind_reg;
    logic             out_kind_next;
    logic             out_last_reg;
    logic             out_last_next;
    logic             slot_free;
    logic [7:0]       cur_byte;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (cnt_reg == CNT_W'(0))
            cur_byte = SYNC_BYTE0;
        else if (cnt_reg == CNT_W'(1))
            cur_byte = SYNC_BYTE1;
        else if (cnt_reg == CNT_W'(2))
            cur_byte = kind_code(kind_reg);
        else
            cur_byte = pay_reg[PAY_W-1 -: 8];
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        kind_next      = kind_reg;
        pay_next       = pay_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        if (slot_free)
            out_valid_next = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_status.nonempty)
                begin
                    pop        = 1'b1;
                    kind_next  = head_kind;
                    pay_next   = head_payload;
                    cnt_next   = '0;
                    state_next = BK_SEND;
                end
            end
            BK_SEND:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = cur_byte;
                    out_kind_next  = kind_reg;
                    out_last_next  = cnt_reg == LAST_IDX;
                    cnt_next       = cnt_reg + CNT_W'(1);
                    if (cnt_reg >= CNT_W'(HEADER_LEN))
                        pay_next = {pay_reg[PAY_W-9:0], 8'h00};
                    if (cnt_reg == LAST_IDX)
                        state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        pay_reg      <= pay_next;
        out_byte_reg <= out_byte_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign frame_byte = out_byte_reg;
    assign frame_kind = out_kind_reg;
    assign frame_last = out_last_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_SEND) |-> (cnt_reg <= LAST_IDX))
        else $error("byte index past frame end");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == BK_SEND) && (cnt_reg == CNT_W'(0)))
        else $error("frame load did not start a new frame");

endmodule

`default_nettype wire

// File: design/sensor_sample_scheduler_framer.sv
// Sensor sample scheduler and framer, top level.
// Depends on sssf_pkg, sssf_front, sssf_queue and sssf_back.
//
// Input channel (in_valid/in_stall): one item per cycle while not stalled,
// either a raw timer tick or a pressure-ready event with the current
// channel and fresh samples. The front end handles each item in the cycle
// it is accepted; when an item completes a frame, the frame is pushed into
// a two-entry frame queue; in_stall is high only while it holds two frames.
// Output channel (out_valid/out_stall): each frame leaves as FRAME_LENGTH
// items, one byte per cycle while the receiver does not stall, from a
// registered output stage; frame_last marks the final byte. A completed
// frame goes from the queue into the serializer and then the output
// register; after a frame's last byte the serializer returns to idle first.
// A stalled receiver holds the output byte; the queue then fills and stalls
// the input side.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
// a new tick_reload is used at the next divider reload.
// Reset restores register defaults, clears counters and fill levels and
// empties the queue; no clearing pass is needed.
`default_nettype none

module sensor_sample_scheduler_framer
    import sssf_pkg::*;
#(
    parameter int FRAME_LENGTH = FRAME_LENGTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        operation,
    input  wire logic [7:0]  channel,
    input  wire logic [15:0] temperature_sample,
    input  wire logic [23:0] pressure_sample,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       frame_byte,
    output logic             frame_kind,
    output logic             frame_last
);

    localparam int PAY_W = (FRAME_LENGTH - HEADER_LEN) * 8;

    logic             accept;
    logic             push;
    logic             push_kind;
    logic [PAY_W-1:0] push_payload;
    logic             pop;
    logic             head_kind;
    logic [PAY_W-1:0] head_payload;
    q_stat_t          q_status;

    assign in_stall = q_status.full;
    assign accept   = in_valid && !in_stall;

    sssf_front #(
        .FRAME_LENGTH (FRAME_LENGTH)
    ) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .accept             (accept),
        .operation          (operation),
        .channel            (channel),
        .temperature_sample (temperature_sample),
        .pressure_sample    (pressure_sample),
        .push               (push),
        .push_kind          (push_kind),
        .push_payload       (push_payload)
    );

    sssf_queue #(
        .FRAME_LENGTH (FRAME_LENGTH)
    ) u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .push_kind    (push_kind),
        .push_payload (push_payload),
        .pop          (pop),
        .head_kind    (head_kind),
        .head_payload (head_payload),
        .status       (q_status)
    );

    sssf_back #(
        .FRAME_LENGTH (FRAME_LENGTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .head_kind    (head_kind),
        .head_payload (head_payload),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_byte   (frame_byte),
        .frame_kind   (frame_kind),
        .frame_last   (frame_last)
    );

endmodule

`default_nettype wire
